// ===== hdl/pcs_pkg.sv =====
package pcs_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] FN_IF     = 3'd0;
  localparam logic [2:0] FN_IFDEF  = 3'd1;
  localparam logic [2:0] FN_IFNDEF = 3'd2;
  localparam logic [2:0] FN_ELSE   = 3'd3;
  localparam logic [2:0] FN_ELIF   = 3'd4;
  localparam logic [2:0] FN_ENDIF  = 3'd5;

  localparam logic [1:0] ST_TRUE  = 2'd0;
  localparam logic [1:0] ST_FALSE = 2'd1;
  localparam logic [1:0] ST_NEVER = 2'd2;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_REPEAT_ELSE = 3'd1;
  localparam logic [2:0] ERR_STRAY_ELIF  = 3'd2;
  localparam logic [2:0] ERR_STRAY_ELSE  = 3'd3;
  localparam logic [2:0] ERR_STRAY_ENDIF = 3'd4;
  localparam logic [2:0] ERR_OVERFLOW    = 3'd5;

  typedef struct packed {
    logic [2:0] func;
    logic       cond;
    logic       name_ok;
  } in_item_t;

  typedef struct packed {
    logic       active;
    logic [1:0] cur_state;
    logic [4:0] depth;
    logic [2:0] error;
    logic       bad_name;
  } out_item_t;

  // top of stack plus the saved entry directly below it
  typedef struct packed {
    logic [1:0]       cur_state;
    logic             cur_else;
    logic [LVL_W-1:0] level;
    logic [1:0]       below_state;
  } stk_view_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       wr_top;
    logic [1:0] st;
    logic       els;
  } stk_upd_t;

endpackage

// ===== hdl/pcs_stack.sv =====
module pcs_stack (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  pcs_pkg::stk_upd_t   upd,
  output pcs_pkg::stk_view_t  view
);

  logic [1:0]                cur_state_r, cur_state_nxt;
  logic                      cur_else_r, cur_else_nxt;
  logic [pcs_pkg::LVL_W-1:0] level_r, level_nxt;
  logic [1:0]                sv_state_r [pcs_pkg::STACK_DEPTH];
  logic                      sv_else_r  [pcs_pkg::STACK_DEPTH];

  always_comb begin
    cur_state_nxt = cur_state_r;
    cur_else_nxt  = cur_else_r;
    level_nxt     = level_r;
    if (en) begin
      if (upd.push) begin
        cur_state_nxt = upd.st;
        cur_else_nxt  = 1'b0;
        level_nxt     = level_r + pcs_pkg::LVL_W'(1);
      end else if (upd.pop) begin
        cur_state_nxt = sv_state_r[0];
        cur_else_nxt  = sv_else_r[0];
        level_nxt     = level_r - pcs_pkg::LVL_W'(1);
      end else if (upd.wr_top) begin
        cur_state_nxt = upd.st;
        cur_else_nxt  = upd.els;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_state_r <= pcs_pkg::ST_TRUE;
      cur_else_r  <= 1'b0;
      level_r     <= '0;
    end else begin
      cur_state_r <= cur_state_nxt;
      cur_else_r  <= cur_else_nxt;
      level_r     <= level_nxt;
    end
  end

  // saved levels shift down on push and up on pop
  always_ff @(posedge clk) begin
    if (en && upd.push) begin
      sv_state_r[0] <= cur_state_r;
      sv_else_r[0]  <= cur_else_r;
      for (int i = 1; i < pcs_pkg::STACK_DEPTH; i++) begin
        sv_state_r[i] <= sv_state_r[i-1];
        sv_else_r[i]  <= sv_else_r[i-1];
      end
    end else if (en && upd.pop) begin
      for (int i = 0; i < pcs_pkg::STACK_DEPTH - 1; i++) begin
        sv_state_r[i] <= sv_state_r[i+1];
        sv_else_r[i]  <= sv_else_r[i+1];
      end
    end
  end

  assign view.cur_state   = cur_state_r;
  assign view.cur_else    = cur_else_r;
  assign view.level       = level_r;
  assign view.below_state = sv_state_r[0];

endmodule

// ===== hdl/pcs_step.sv =====
module pcs_step (
  input  pcs_pkg::in_item_t   item,
  input  pcs_pkg::stk_view_t  view,
  output pcs_pkg::stk_upd_t   upd,
  output pcs_pkg::out_item_t  res
);

  logic [1:0]                push_st;
  logic                      want;
  logic                      bad;
  logic                      full;
  logic [2:0]                err;
  logic [1:0]                new_state;
  logic [pcs_pkg::LVL_W-1:0] new_level;

  assign full = (view.level >= pcs_pkg::LVL_W'(pcs_pkg::STACK_DEPTH));
  assign want = (item.func == pcs_pkg::FN_IFDEF) ? item.cond : !item.cond;

  always_comb begin
    upd       = '0;
    err       = pcs_pkg::ERR_NONE;
    bad       = 1'b0;
    push_st   = pcs_pkg::ST_NEVER;
    new_state = view.cur_state;
    new_level = view.level;
    case (item.func)
      pcs_pkg::FN_IF, pcs_pkg::FN_IFDEF, pcs_pkg::FN_IFNDEF: begin
        if (view.cur_state == pcs_pkg::ST_TRUE) begin
          if (item.func == pcs_pkg::FN_IF) begin
            push_st = item.cond ? pcs_pkg::ST_TRUE : pcs_pkg::ST_FALSE;
          end else if (item.name_ok) begin
            push_st = want ? pcs_pkg::ST_TRUE : pcs_pkg::ST_FALSE;
          end else begin
            push_st = pcs_pkg::ST_FALSE;
            bad     = 1'b1;
          end
        end
        if (full) begin
          err = pcs_pkg::ERR_OVERFLOW;
        end else begin
          upd.push  = 1'b1;
          upd.st    = push_st;
          new_state = push_st;
          new_level = view.level + pcs_pkg::LVL_W'(1);
        end
      end
      pcs_pkg::FN_ELSE, pcs_pkg::FN_ELIF: begin
        if (view.level == '0) begin
          err = (item.func == pcs_pkg::FN_ELIF) ? pcs_pkg::ERR_STRAY_ELIF
                                                : pcs_pkg::ERR_STRAY_ELSE;
        end else if (view.cur_else) begin
          err = pcs_pkg::ERR_REPEAT_ELSE;
        end else begin
          if (view.cur_state == pcs_pkg::ST_TRUE) begin
            new_state = pcs_pkg::ST_NEVER;
          end else if (view.cur_state == pcs_pkg::ST_FALSE) begin
            if (item.func == pcs_pkg::FN_ELIF) begin
              new_state = item.cond ? pcs_pkg::ST_TRUE : pcs_pkg::ST_FALSE;
            end else begin
              new_state = pcs_pkg::ST_TRUE;
            end
          end
          upd.wr_top = 1'b1;
          upd.st     = new_state;
          upd.els    = (item.func == pcs_pkg::FN_ELSE);
        end
      end
      pcs_pkg::FN_ENDIF: begin
        if (view.level == '0) begin
          err = pcs_pkg::ERR_STRAY_ENDIF;
        end else begin
          upd.pop   = 1'b1;
          new_state = view.below_state;
          new_level = view.level - pcs_pkg::LVL_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign res.active    = (new_state == pcs_pkg::ST_TRUE);
  assign res.cur_state = new_state;
  assign res.depth     = 5'(new_level);
  assign res.error     = err;
  assign res.bad_name  = bad;

endmodule

// ===== hdl/preprocessor_conditional_stack.sv =====
// channel | ports                               | payload
// input   | in_valid, in_ready, in_data         | pcs_pkg::in_item_t
// output  | out_valid, out_ready, out_data      | pcs_pkg::out_item_t
//
// one directive per cycle sustained while out_ready holds; each result passes
// through the input register, then the result register
// the stack update and result are formed combinationally from the top of stack
// synchronous active-low reset empties the stack to level zero, state true
// a stalled result holds in the result register while the input register
// still takes one more transaction
module preprocessor_conditional_stack (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pcs_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pcs_pkg::out_item_t  out_data
);

  logic                s1_valid_r, s1_valid_nxt;
  pcs_pkg::in_item_t   s1_data_r;
  logic                out_valid_r, out_valid_nxt;
  pcs_pkg::out_item_t  out_data_r;
  logic                advance;
  logic                in_accept;
  pcs_pkg::stk_view_t  view;
  pcs_pkg::stk_upd_t   upd;
  pcs_pkg::out_item_t  res;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  pcs_step u_step (
    .item (s1_data_r),
    .view (view),
    .upd  (upd),
    .res  (res)
  );

  pcs_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .upd   (upd),
    .view  (view)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/pcs_checker.sv =====
module pcs_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                out_valid,
  input  logic                out_ready,
  input  pcs_pkg::out_item_t  out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.active == (out_data.cur_state == pcs_pkg::ST_TRUE)))
    else $error("active disagrees with state");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.depth <= 5'(pcs_pkg::STACK_DEPTH))
    else $error("depth beyond stack");

  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error == pcs_pkg::ERR_OVERFLOW
      |-> out_data.depth == 5'(pcs_pkg::STACK_DEPTH))
    else $error("overflow below full depth");

  a_bad_name: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_name && out_data.error == pcs_pkg::ERR_NONE
      |-> out_data.cur_state == pcs_pkg::ST_FALSE)
    else $error("invalid name did not open a false level");

endmodule

bind preprocessor_conditional_stack pcs_checker u_pcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
